// ===== sv/clru_pkg.sv =====
// Shared types, codes and constants for the LRU age replacement block.
package clru_pkg;

  localparam int SETS_DEF  = 2048;
  localparam int WAYS_DEF  = 16;
  localparam int MAX_WAYS  = 16;
  localparam int AGE_W     = 4;
  localparam int SET_IDX_W = 11;
  localparam int WAY_IDX_W = 4;
  localparam int MASK_W    = 16;
  localparam int SET_MAX_W = 16;  // enough for the largest set count
  localparam int Q_DEPTH   = 2;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_VICTIM = 1'b1;

  typedef struct packed {
    logic                 command;
    logic [SET_IDX_W-1:0] set_index;
    logic [WAY_IDX_W-1:0] way_index;
    logic                 is_hit;
    logic                 is_writeback;
    logic [MASK_W-1:0]    valid_mask;
  } req_t;

  typedef struct packed {
    logic [WAY_IDX_W-1:0] victim_way;
    logic                 took_invalid;
  } rsp_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_TOUCH,
    OP_VICTIM
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [SET_MAX_W-1:0] set_idx;
    logic [WAY_IDX_W-1:0] way;
    logic [MASK_W-1:0]    mask;
  } job_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } bk_state_t;

endpackage

// ===== sv/cache_lru_age_replacement.sv =====
// Top level of the true-LRU age replacement block.
//
//   channel  dir  handshake            payload  beat
//   req      in   req_valid/req_ready  req_t    update or victim command
//   rsp      out  rsp_valid/rsp_ready  rsp_t    victim way, took_invalid
//
// In the back end a beat first reads the set's age row from the age memory
// (state IDLE), then computes the result and, for an update, writes the new
// row back (state EXEC); the back end takes the next beat only after EXEC.
// After reset a clearing pass writes every row to WAYS-1 ages, with req_ready
// low throughout.
// A held rsp stalls the back end only; the queue and front stages keep taking
// beats until they fill.
module cache_lru_age_replacement import clru_pkg::*; #(
  parameter int SETS = SETS_DEF,
  parameter int WAYS = WAYS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic busy;       // clearing pass running
  logic push, full; // front to queue
  logic pop, empty; // queue to back end
  job_t job_front, job_back;

  // front: range fold of the set index, job classification
  clru_front #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .busy      (busy),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .push      (push),
    .job       (job_front),
    .full      (full)
  );

  // decouples the front from a stalled back end
  clru_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .job_in  (job_front),
    .full    (full),
    .pop     (pop),
    .job_out (job_back),
    .empty   (empty)
  );

  // back: age memory and the read-modify-write sequencer
  clru_back #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .job_in    (job_back),
    .pop       (pop),
    .busy      (busy),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ===== sv/clru_front.sv =====
// Front end: takes request beats, folds the set index into range, classifies the job.
module clru_front import clru_pkg::*; #(
  parameter int SETS = SETS_DEF,
  parameter int WAYS = WAYS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic busy,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic push,
  output job_t job,
  input  logic full
);

  // set_index mod SETS by reciprocal multiply; quotient may be one low
  localparam int RECIP_SH = 22;
  localparam int RECIP_W  = 23;
  localparam int SETS_W   = 17;
  localparam int PROD_W   = SET_IDX_W + RECIP_W;
  localparam int QD_W     = SET_IDX_W + SETS_W;
  localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'((64'd1 << RECIP_SH) / SETS);
  localparam logic [SETS_W-1:0]  SETS_V = SETS_W'(SETS);

  logic                 a_valid, b_valid;
  req_t                 a_req, b_req;
  logic [SET_IDX_W-1:0] a_quo, b_rem;

  logic [PROD_W-1:0]    prod;
  logic [SET_IDX_W-1:0] quo;
  logic [QD_W-1:0]      qd;
  logic [SET_IDX_W-1:0] rem_a;
  logic [SETS_W-1:0]    rem_wide, rem_corr;
  logic                 b_free, a_move, way_ok;

  assign prod  = PROD_W'(req.set_index) * PROD_W'(RECIP);
  assign quo   = prod[RECIP_SH +: SET_IDX_W];
  assign qd    = QD_W'(a_quo) * QD_W'(SETS_V);
  assign rem_a = a_req.set_index - qd[SET_IDX_W-1:0];

  assign rem_wide = {{(SETS_W-SET_IDX_W){1'b0}}, b_rem};
  assign rem_corr = (rem_wide >= SETS_V) ? rem_wide - SETS_V : rem_wide;

  assign push      = b_valid && !full;
  assign b_free    = !b_valid || push;
  assign a_move    = a_valid && b_free;
  assign req_ready = !busy && (!a_valid || a_move);

  assign way_ok = {1'b0, b_req.way_index} < (WAY_IDX_W+1)'(WAYS);

  always_comb begin
    job.set_idx = rem_corr[SET_MAX_W-1:0];
    job.way     = b_req.way_index;
    job.mask    = b_req.valid_mask;
    if (b_req.command == CMD_VICTIM) begin
      job.op = OP_VICTIM;
    end else if (b_req.command == CMD_UPDATE && way_ok &&
                 !(b_req.is_hit && b_req.is_writeback)) begin
      job.op = OP_TOUCH;
    end else begin
      job.op = OP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (req_ready) a_valid <= req_valid;
      if (b_free)    b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      a_req <= req;
      a_quo <= quo;
    end
    if (a_move) begin
      b_req <= a_req;
      b_rem <= rem_a;
    end
  end

endmodule

// ===== sv/clru_fifo.sv =====
// Short job queue between front and back end.
module clru_fifo import clru_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t job_in,
  output logic full,
  input  logic pop,
  output job_t job_out,
  output logic empty
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  job_t             slots [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = count == CNT_W'(Q_DEPTH);
  assign empty   = count == '0;
  assign job_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= job_in;
  end

endmodule

// ===== sv/clru_back.sv =====
// Back end: age memory, clearing pass, read-modify-write sequencer and result register.
module clru_back import clru_pkg::*; #(
  parameter int SETS = SETS_DEF,
  parameter int WAYS = WAYS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic empty,
  input  job_t job_in,
  output logic pop,
  output logic busy,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int ROW_W = WAYS * AGE_W;
  localparam logic [ROW_W-1:0]    RESET_ROW  = {WAYS{AGE_W'(WAYS-1)}};
  localparam logic [MAX_WAYS-1:0] WAY_FIELD  = MAX_WAYS'((32'd1 << WAYS) - 1);

  // lowest index holding the greatest age; ties keep the left branch
  function automatic logic [WAY_IDX_W-1:0] oldest(input logic [MAX_WAYS*AGE_W-1:0] flat);
    logic [AGE_W-1:0]     ta [MAX_WAYS];
    logic [WAY_IDX_W-1:0] ti [MAX_WAYS];
    for (int i = 0; i < MAX_WAYS; i++) begin
      ta[i] = flat[i*AGE_W +: AGE_W];
      ti[i] = WAY_IDX_W'(i);
    end
    for (int s = 1; s < MAX_WAYS; s = s * 2) begin
      for (int i = 0; i < MAX_WAYS; i = i + 2 * s) begin
        if (ta[i+s] > ta[i]) begin
          ta[i] = ta[i+s];
          ti[i] = ti[i+s];
        end
      end
    end
    return ti[0];
  endfunction

  logic [ROW_W-1:0] ages_mem [SETS];
  logic [ROW_W-1:0] rd_data;

  bk_state_t state, state_next;
  logic [SW-1:0] clr_cnt;
  job_t          cur;

  logic                   rd_en, wr_en, out_load, done_ok, clr_last;
  logic [SW-1:0]          rd_addr, wr_addr;
  logic [ROW_W-1:0]       wr_data, touched;
  logic [MAX_WAYS*AGE_W-1:0] age_flat;
  logic [AGE_W-1:0]       ref_age;
  logic [MAX_WAYS-1:0]    inv, inv_low;
  logic [WAY_IDX_W-1:0]   inv_idx;
  rsp_t                   res;

  assign done_ok  = !rsp_valid || rsp_ready;
  assign clr_last = clr_cnt == SW'(SETS-1);

  // unpack the row, padding unused ways with age zero
  for (genvar g = 0; g < MAX_WAYS; g++) begin : g_age
    if (g < WAYS) begin : g_real
      assign age_flat[g*AGE_W +: AGE_W] = rd_data[g*AGE_W +: AGE_W];
      assign touched[g*AGE_W +: AGE_W] =
        (cur.way == WAY_IDX_W'(g)) ? '0 :
        (rd_data[g*AGE_W +: AGE_W] < ref_age) ? rd_data[g*AGE_W +: AGE_W] + 1'b1 :
                                                rd_data[g*AGE_W +: AGE_W];
    end else begin : g_pad
      assign age_flat[g*AGE_W +: AGE_W] = '0;
    end
  end

  assign ref_age = age_flat[cur.way*AGE_W +: AGE_W];

  assign inv     = ~cur.mask & WAY_FIELD;
  assign inv_low = inv & (~inv + 1'b1);

  always_comb begin
    inv_idx = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      inv_idx = inv_idx | (inv_low[i] ? WAY_IDX_W'(i) : '0);
    end
  end

  always_comb begin
    res = '0;
    case (cur.op)
      OP_VICTIM: begin
        res.took_invalid = |inv;
        res.victim_way   = (|inv) ? inv_idx : oldest(age_flat);
      end
      default: res = '0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR: if (clr_last) state_next = BK_IDLE;
      BK_IDLE:  if (!empty) state_next = BK_EXEC;
      BK_EXEC:  if (done_ok) state_next = BK_IDLE;
      default:  state_next = BK_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    pop      = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    out_load = 1'b0;
    busy     = 1'b0;
    wr_addr  = cur.set_idx[SW-1:0];
    wr_data  = touched;
    rd_addr  = job_in.set_idx[SW-1:0];
    case (state)
      BK_CLEAR: begin
        busy    = 1'b1;
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = RESET_ROW;
      end
      BK_IDLE: begin
        pop   = !empty;
        rd_en = !empty;
      end
      BK_EXEC: begin
        out_load = done_ok;
        wr_en    = done_ok && (cur.op == OP_TOUCH);
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (out_load)       rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop)      cur <= job_in;
    if (out_load) rsp <= res;
  end

  always_ff @(posedge clk) begin
    if (wr_en) ages_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= ages_mem[rd_addr];
  end

endmodule

// ===== sv/clru_checker.sv =====
// Port-level checks for the LRU age replacement block, bound to the top level.
module clru_checker import clru_pkg::*; #(
  parameter int WAYS = WAYS_DEF
) (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  localparam int CAP = 6;  // two front stages, two queue slots, one in work, one result

  logic [3:0] outstanding;
  logic       req_beat, rsp_beat;

  assign req_beat = req_valid && req_ready;
  assign rsp_beat = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 4'(req_beat) - 4'(rsp_beat);
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("rsp changed while stalled");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !req_ready && !rsp_valid)
    else $error("beat possible before clearing pass");

  a_no_orphan_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> outstanding != '0)
    else $error("rsp without a pending req");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    outstanding <= 4'(CAP))
    else $error("more beats in flight than storage");

  a_way_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> {1'b0, rsp.victim_way} < (WAY_IDX_W+1)'(WAYS))
    else $error("victim way out of range");

endmodule

bind cache_lru_age_replacement clru_checker #(.WAYS(WAYS)) u_clru_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for the true-LRU age replacement block.
module testbench;
  import clru_pkg::*;

  localparam int SETS       = SETS_DEF;
  localparam int WAYS       = WAYS_DEF;
  localparam int CYCLE_CAP  = 300000;  // clearing pass + every beat at its slowest, many times over
  localparam int RANDOM_N   = 1300;
  localparam int HOLD_LEN   = 400;     // long receiver hold-off, fills the block
  localparam int DRAIN_WAIT = 16;      // margin after the drain for any late response

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  cache_lru_age_replacement #(.SETS(SETS), .WAYS(WAYS)) uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Own copy of the age table: age_tab[set][way], 0 = most recently used.
  logic [AGE_W-1:0] age_tab [SETS][MAX_WAYS];

  req_t pending_beats[$];   // beats still to be offered on req
  rsp_t expected_rsp[$];    // predicted responses, oldest first

  int   cycle_count = 0;
  int   error_count = 0;
  int   beats_sent  = 0;
  int   rsp_count   = 0;
  int   hold_left   = 0;
  bit   held_once   = 1'b0;
  bit   req_fire    = 1'b0;  // beat taken at the last rising edge
  rsp_t want;

  task automatic report(input string msg);
    error_count++;
    $display("mismatch @%0d: %s", cycle_count, msg);
  endtask

  // Applies one beat to the age table and returns the response it should give.
  // Victim: lowest invalid way wins outright; otherwise the lowest-index way
  // with the greatest age. Update: ways younger than the touched way age by one,
  // the touched way drops to 0; a writeback hit leaves the set alone.
  function automatic rsp_t lru_outcome(input req_t b);
    rsp_t        res;
    int          s;
    int          best;
    logic [3:0]  ref_age;
    bit          found;
    res   = '0;
    s     = int'(b.set_index) % SETS;
    found = 1'b0;
    if (b.command == CMD_VICTIM) begin
      for (int w = 0; w < WAYS; w++) begin
        if (!found && !b.valid_mask[w]) begin
          found            = 1'b1;
          res.victim_way   = WAY_IDX_W'(w);
          res.took_invalid = 1'b1;
        end
      end
      if (!found) begin
        best = 0;
        for (int w = 1; w < WAYS; w++)
          if (age_tab[s][w] > age_tab[s][best]) best = w;
        res.victim_way = WAY_IDX_W'(best);
      end
    end else if (!(b.is_hit && b.is_writeback) && int'(b.way_index) < WAYS) begin
      ref_age = age_tab[s][b.way_index];
      for (int w = 0; w < WAYS; w++)
        if (age_tab[s][w] < ref_age) age_tab[s][w] = age_tab[s][w] + 1'b1;
      age_tab[s][b.way_index] = '0;
    end
    return res;
  endfunction

  task automatic push_update(input int set, input int way, input bit hit, input bit wb);
    req_t b;
    b              = '0;
    b.command      = CMD_UPDATE;
    b.set_index    = SET_IDX_W'(set);
    b.way_index    = WAY_IDX_W'(way);
    b.is_hit       = hit;
    b.is_writeback = wb;
    b.valid_mask   = MASK_W'($urandom_range(0, 65535));
    pending_beats.push_back(b);
  endtask

  task automatic push_victim(input int set, input logic [MASK_W-1:0] mask);
    req_t b;
    b              = '0;
    b.command      = CMD_VICTIM;
    b.set_index    = SET_IDX_W'(set);
    b.way_index    = WAY_IDX_W'($urandom_range(0, 15));
    b.is_hit       = 1'($urandom_range(0, 1));
    b.is_writeback = 1'($urandom_range(0, 1));
    b.valid_mask   = mask;
    pending_beats.push_back(b);
  endtask

  // Idle roughly 18 beats in a hundred, none inside the quiet window.
  function automatic bit idle_now(input int pos, input int quiet_lo, input int quiet_hi);
    if (pos >= quiet_lo && pos < quiet_hi) return 1'b0;
    return $urandom_range(0, 99) < 18;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus: directed corner beats, then random traffic concentrated on a few
  // hot sets so that ages spread out and victim choice gets exercised properly.
  // ---------------------------------------------------------------------------
  initial begin
    int hot_sets [8];
    int pick;
    logic [MASK_W-1:0] mask;
    hot_sets = '{0, 2047, 1, 1024, 5, 777, 1500, 42};
    for (int s = 0; s < SETS; s++)
      for (int w = 0; w < MAX_WAYS; w++)
        age_tab[s][w] = (w < WAYS) ? AGE_W'(WAYS - 1) : '0;

    // fresh sets: all ages tied, so the lowest way is the oldest
    push_victim(0, 16'hFFFF);
    push_victim(0, 16'h0000);      // everything invalid
    push_victim(2047, 16'h7FFF);   // only the top way invalid
    push_victim(2047, 16'hFFFE);
    push_update(0, 15, 1'b1, 1'b0);  // read hit
    push_update(0, 0, 1'b0, 1'b1);   // writeback miss updates as normal
    push_update(0, 7, 1'b1, 1'b1);   // writeback hit: no change
    push_victim(0, 16'hFFFF);
    push_update(0, 7, 1'b0, 1'b0);
    push_update(0, 15, 1'b1, 1'b0);  // re-touch: only younger ways age
    push_victim(0, 16'hFFFF);
    push_update(2047, 0, 1'b1, 1'b0);
    push_update(2047, 15, 1'b0, 1'b0);
    push_update(2047, 0, 1'b1, 1'b0);
    push_victim(2047, 16'hFFFF);
    push_victim(1024, 16'hBFFF);
    push_update(1024, 14, 1'b0, 1'b1);
    push_victim(1024, 16'hFFFF);
    push_victim(2047, 16'h8000);

    for (int i = 0; i < RANDOM_N; i++) begin
      pick = ($urandom_range(0, 99) < 75) ? hot_sets[$urandom_range(0, 7)]
                                          : int'($urandom_range(0, SETS - 1));
      if ($urandom_range(0, 99) < 62) begin
        push_update(pick, $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
      end else begin
        case ($urandom_range(0, 9))
          0, 1:    mask = MASK_W'($urandom_range(0, 65535));
          2, 3:    mask = ~(MASK_W'(1) << $urandom_range(0, 15));
          default: mask = '1;
        endcase
        push_victim(pick, mask);
      end
    end

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // drain: everything offered, accepted and answered
    while (pending_beats.size() != 0 || req_valid || expected_rsp.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_rsp.size() != 0)
      report($sformatf("%0d responses never arrived", expected_rsp.size()));

    if (error_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_CAP);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples both handshakes at the rising edge. A taken req beat is
  // run through the predictor straight away (beats are answered in order), a
  // taken rsp beat is checked against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    req_fire = 1'b0;
    if (!rst) begin
      if (req_valid && req_ready) begin
        expected_rsp.push_back(lru_outcome(req));
        req_fire = 1'b1;
      end
      if (rsp_valid && rsp_ready) begin
        rsp_count++;
        if (expected_rsp.size() == 0) begin
          report($sformatf("unexpected rsp way=%0d inv=%0b", rsp.victim_way,
                           rsp.took_invalid));
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.victim_way !== want.victim_way)
            report($sformatf("rsp %0d victim_way %0d, want %0d", rsp_count,
                             rsp.victim_way, want.victim_way));
          if (rsp.took_invalid !== want.took_invalid)
            report($sformatf("rsp %0d took_invalid %0b, want %0b", rsp_count,
                             rsp.took_invalid, want.took_invalid));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: moves on the falling edge. Once valid is up it is held with the
  // same beat until the monitor saw it taken; only then may a gap be inserted.
  // Beats 500..759 go out back to back.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst && (!req_valid || req_fire)) begin
      if (pending_beats.size() != 0 && !idle_now(beats_sent, 500, 760)) begin
        req       <= pending_beats.pop_front();
        req_valid <= 1'b1;
        beats_sent++;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, a quiet window (responses 900..1149) with
  // ready held high, and one long hold-off after 300 responses while the
  // driver keeps offering, so the block backs up and drops req_ready.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (!held_once && rsp_count >= 300) begin
        held_once = 1'b1;
        hold_left = HOLD_LEN;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= !idle_now(rsp_count, 900, 1150);
      end
    end
  end

endmodule
